### rtl/cisp_pkg.sv
// Package of types and constants shared by the CBOR item skip parser modules.
`timescale 1ns / 1ps
package cisp_pkg;

   // Frame kinds on the nesting stack.
   localparam logic [2:0] KIND_DARR = 3'd0;
   localparam logic [2:0] KIND_DMAP = 3'd1;
   localparam logic [2:0] KIND_TAG  = 3'd2;
   localparam logic [2:0] KIND_IARR = 3'd3;
   localparam logic [2:0] KIND_IMAP = 3'd4;

   // Parse phases.
   localparam logic [2:0] PH_HEAD    = 3'd0;
   localparam logic [2:0] PH_ARG     = 3'd1;
   localparam logic [2:0] PH_PAYLOAD = 3'd2;
   localparam logic [2:0] PH_CHEAD   = 3'd3;
   localparam logic [2:0] PH_CARG    = 3'd4;
   localparam logic [2:0] PH_CPAY    = 3'd5;

   // Result status codes.
   localparam logic [2:0] ST_PENDING   = 3'd0;
   localparam logic [2:0] ST_COMPLETE  = 3'd1;
   localparam logic [2:0] ST_MALFORMED = 3'd2;
   localparam logic [2:0] ST_DEPTH     = 3'd3;
   localparam logic [2:0] ST_TRUNC     = 3'd4;

   // Datapath operations issued by the controller.
   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_CONSUME = 3'd1;
   localparam logic [2:0] OP_POP    = 3'd2;
   localparam logic [2:0] OP_CLEAR  = 3'd3;
   localparam logic [2:0] OP_HOLD   = 3'd4;

   // Controller to datapath.
   typedef struct packed {
      logic [2:0] op;
      logic       last;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic       done;
      logic       finish;
      logic [2:0] status;
   } sts_type;

endpackage

### rtl/cisp_datapath.sv
// Datapath of the CBOR item skip parser: head decode, frame stack and counters.
`timescale 1ns / 1ps
module cisp_datapath import cisp_pkg::*; #(
   parameter int MAX_NEST = 8,
   parameter int LW = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   input  logic [7:0]    data_byte,
   input  logic [3:0]    depth_limit,
   output sts_type       sts,
   output logic [15:0]   item_length,
   output logic [3:0]    nest_level
);

   localparam int DEPTH = MAX_NEST + 1;
   localparam int IW = $clog2(DEPTH);

   // Frame store, undefined until written.
   logic [33:0] rem_mem [DEPTH];
   logic [2:0]  kind_mem [DEPTH];

   logic [LW-1:0] level_ff, level_in;
   logic [2:0]    phase_ff, phase_in;
   logic [2:0]    argleft_ff, argleft_in;
   logic [31:0]   arg_ff, arg_in;
   logic [2:0]    major_ff, major_in;
   logic [31:0]   pay_ff, pay_in;
   logic [15:0]   len_ff, len_in;

   logic          wr_en;
   logic [IW-1:0] wr_idx;
   logic [33:0]   wr_rem;
   logic [2:0]    wr_kind;

   logic [2:0] ma;
   logic [4:0] ai;
   logic [IW-1:0] top;
   logic [33:0] top_rem;
   logic [2:0] top_kind;
   logic [3:0] lim;
   logic [31:0] hv;
   logic [2:0] hm;
   logic do_head, do_finish, do_push;
   logic [2:0] push_kind;
   logic [33:0] push_cnt;

   assign ma = data_byte[7:5];
   assign ai = data_byte[4:0];
   assign top = IW'(level_ff - LW'(1));
   assign top_rem = rem_mem[top];
   assign top_kind = kind_mem[top];
   assign lim = (MAX_NEST > 15 || depth_limit < 4'(MAX_NEST)) ? depth_limit : 4'(MAX_NEST);

   // Next-state logic for one consume, pop, clear or hold step.
   always_comb begin
      level_in = level_ff; phase_in = phase_ff; argleft_in = argleft_ff;
      arg_in = arg_ff; major_in = major_ff; pay_in = pay_ff; len_in = len_ff;
      wr_en = 1'b0; wr_idx = top; wr_rem = top_rem; wr_kind = top_kind;
      sts = '0;
      do_head = 1'b0; do_finish = 1'b0; do_push = 1'b0;
      push_kind = KIND_DARR; push_cnt = '0;
      hv = {27'd0, ai}; hm = ma;
      unique case (cmd.op)
         OP_CLEAR, OP_HOLD: begin
            if (cmd.op == OP_CLEAR || cmd.last) begin
               level_in = '0; phase_in = PH_HEAD; argleft_in = '0; arg_in = '0;
               major_in = '0; pay_in = '0; len_in = '0;
            end
            sts.done = 1'b1;
         end
         OP_POP: do_finish = 1'b1;
         OP_CONSUME: begin
            if (len_ff != 16'hFFFF) len_in = len_ff + 16'd1;
            sts.done = 1'b1;
            case (phase_ff)
               PH_HEAD: begin
                  if (level_ff != '0 && data_byte == 8'hFF &&
                      (top_kind == KIND_IARR ||
                       (top_kind == KIND_IMAP && !top_rem[0]))) begin
                     level_in = level_ff - LW'(1);
                     sts.done = 1'b0; sts.finish = 1'b1;
                  end else if (level_ff > LW'(lim)) begin
                     sts.status = ST_DEPTH;
                  end else if (ai == 5'd31) begin
                     if (ma == 3'd2 || ma == 3'd3) begin
                        major_in = ma; phase_in = PH_CHEAD;
                     end else if (ma == 3'd4) begin
                        do_push = 1'b1; push_kind = KIND_IARR;
                     end else if (ma == 3'd5) begin
                        do_push = 1'b1; push_kind = KIND_IMAP;
                     end else sts.status = ST_MALFORMED;
                  end else if (ai >= 5'd27) begin
                     sts.status = ST_MALFORMED;
                  end else if (ai >= 5'd24) begin
                     major_in = ma; arg_in = '0; phase_in = PH_ARG;
                     argleft_in = (ai == 5'd24) ? 3'd1 : (ai == 5'd25) ? 3'd2 : 3'd4;
                  end else do_head = 1'b1;
               end
               PH_ARG: begin
                  arg_in = {arg_ff[23:0], data_byte};
                  argleft_in = argleft_ff - 3'd1;
                  if (argleft_in == 3'd0) begin
                     do_head = 1'b1; hv = arg_in; hm = major_ff;
                  end
               end
               PH_PAYLOAD: begin
                  pay_in = pay_ff - 32'd1;
                  if (pay_in == 32'd0) begin
                     phase_in = PH_HEAD; sts.done = 1'b0; sts.finish = 1'b1;
                  end
               end
               PH_CHEAD: begin
                  if (data_byte == 8'hFF) begin
                     phase_in = PH_HEAD; sts.done = 1'b0; sts.finish = 1'b1;
                  end else if (ma != major_ff || ai >= 5'd27) begin
                     sts.status = ST_MALFORMED;
                  end else if (ai >= 5'd24) begin
                     arg_in = '0; phase_in = PH_CARG;
                     argleft_in = (ai == 5'd24) ? 3'd1 : (ai == 5'd25) ? 3'd2 : 3'd4;
                  end else if (ai != 5'd0) begin
                     pay_in = {27'd0, ai}; phase_in = PH_CPAY;
                  end
               end
               PH_CARG: begin
                  arg_in = {arg_ff[23:0], data_byte};
                  argleft_in = argleft_ff - 3'd1;
                  if (argleft_in == 3'd0) begin
                     if (arg_in == 32'd0) phase_in = PH_CHEAD;
                     else begin
                        pay_in = arg_in; phase_in = PH_CPAY;
                     end
                  end
               end
               PH_CPAY: begin
                  pay_in = pay_ff - 32'd1;
                  if (pay_in == 32'd0) phase_in = PH_CHEAD;
               end
               default: sts.status = ST_MALFORMED;
            endcase
            // Head with its argument resolved.
            if (do_head) begin
               phase_in = PH_HEAD;
               case (hm)
                  3'd2, 3'd3: begin
                     if (hv == 32'd0) begin
                        sts.done = 1'b0; sts.finish = 1'b1;
                     end else begin
                        pay_in = hv; phase_in = PH_PAYLOAD;
                     end
                  end
                  3'd4: begin
                     if (hv == 32'd0) begin
                        sts.done = 1'b0; sts.finish = 1'b1;
                     end else begin
                        do_push = 1'b1; push_kind = KIND_DARR; push_cnt = {2'd0, hv};
                     end
                  end
                  3'd5: begin
                     if (hv == 32'd0) begin
                        sts.done = 1'b0; sts.finish = 1'b1;
                     end else begin
                        do_push = 1'b1; push_kind = KIND_DMAP;
                        push_cnt = {1'b0, hv, 1'b0};
                     end
                  end
                  3'd6: begin
                     do_push = 1'b1; push_kind = KIND_TAG; push_cnt = 34'd1;
                  end
                  default: begin
                     sts.done = 1'b0; sts.finish = 1'b1;
                  end
               endcase
            end
            if (do_push) begin
               if (level_ff >= LW'(DEPTH)) sts.status = ST_DEPTH;
               else begin
                  wr_en = 1'b1; wr_idx = IW'(level_ff);
                  wr_kind = push_kind; wr_rem = push_cnt;
                  level_in = level_ff + LW'(1);
               end
            end
         end
         default: ;
      endcase
      // One finish step against the top frame.
      if (do_finish) begin
         sts.done = 1'b1;
         if (level_ff == '0) sts.status = ST_COMPLETE;
         else if (top_kind == KIND_IARR) ;
         else if (top_kind == KIND_IMAP) begin
            wr_en = 1'b1; wr_rem = {top_rem[33:1], ~top_rem[0]};
         end else begin
            wr_en = 1'b1; wr_rem = top_rem - 34'd1;
            if (wr_rem == 34'd0) begin
               level_in = level_ff - LW'(1); sts.done = 1'b0; sts.finish = 1'b1;
            end
         end
      end
   end

   // Frame store write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rem_mem[wr_idx] <= wr_rem;
         kind_mem[wr_idx] <= wr_kind;
      end
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0; phase_ff <= PH_HEAD; argleft_ff <= '0; arg_ff <= '0;
         major_ff <= '0; pay_ff <= '0; len_ff <= '0;
      end else begin
         level_ff <= level_in; phase_ff <= phase_in; argleft_ff <= argleft_in;
         arg_ff <= arg_in; major_ff <= major_in; pay_ff <= pay_in; len_ff <= len_in;
      end
   end

   assign item_length = len_in;
   assign nest_level = 4'(level_in);

endmodule

### rtl/cisp_control.sv
// Controller of the CBOR item skip parser: sequencing, error hold and result register.
`timescale 1ns / 1ps
module cisp_control import cisp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_buffer_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_item_length,
   output logic [3:0]  rsp_nest_level,
   output cmd_type     cmd,
   input  sts_type     sts,
   input  logic [15:0] item_length,
   input  logic [3:0]  nest_level
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_POP  = 2'd1;
   localparam logic [1:0] S_END  = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic        hold_ff, hold_in;
   logic        last_ff, last_in;
   logic        valid_ff, valid_in;
   logic [2:0]  status_ff, status_in;
   logic [15:0] len_ff, len_in;
   logic [3:0]  nest_ff, nest_in;
   logic        fire, out_free;
   logic [2:0]  res;

   assign out_free = !valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == S_IDLE && out_free);
   assign fire = req_valid && !req_stall;

   // Sequencing of consume, pop and result steps.
   always_comb begin
      state_in = state_ff; hold_in = hold_ff; last_in = last_ff;
      valid_in = valid_ff && rsp_stall;
      status_in = status_ff; len_in = len_ff; nest_in = nest_ff;
      cmd.op = OP_NONE; cmd.last = last_ff; res = ST_PENDING;
      unique case (state_ff)
         S_IDLE: begin
            if (fire) begin
               cmd.last = req_buffer_end; last_in = req_buffer_end;
               if (hold_ff) begin
                  cmd.op = OP_HOLD;
                  valid_in = 1'b1; status_in = ST_PENDING; len_in = '0; nest_in = '0;
                  if (req_buffer_end) hold_in = 1'b0;
               end else begin
                  cmd.op = OP_CONSUME;
                  len_in = item_length; nest_in = nest_level;
                  if (sts.finish) state_in = S_POP;
                  else begin
                     res = sts.status; state_in = S_END;
                  end
               end
            end
         end
         S_POP: begin
            cmd.op = OP_POP;
            if (!sts.finish) begin
               res = sts.status; state_in = S_END;
            end
         end
         default: begin
            // Deliver the result of the byte and clear when it ends the parse.
            valid_in = 1'b1; state_in = S_IDLE; status_in = status_ff;
            if (status_ff != ST_PENDING) begin
               cmd.op = OP_CLEAR;
               if (status_ff >= ST_MALFORMED && status_ff != ST_TRUNC) hold_in = !last_ff;
            end
         end
      endcase
      if (state_in == S_END && state_ff != S_END) begin
         nest_in = (res >= ST_MALFORMED) ? nest_ff : nest_level;
         if (state_ff == S_IDLE) nest_in = (res >= ST_MALFORMED) ? nest_level : nest_level;
         if (res == ST_PENDING && last_in) status_in = ST_TRUNC;
         else status_in = res;
      end
   end

   // Control and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; hold_ff <= 1'b0; valid_ff <= 1'b0; last_ff <= 1'b0;
      end else begin
         state_ff <= state_in; hold_ff <= hold_in; valid_ff <= valid_in; last_ff <= last_in;
      end
      status_ff <= status_in; len_ff <= len_in; nest_ff <= nest_in;
   end

   assign rsp_valid = valid_ff && state_ff != S_END;
   assign rsp_status = status_ff;
   assign rsp_item_length = len_ff;
   assign rsp_nest_level = nest_ff;

endmodule

### rtl/cbor_item_skip_parser_core.sv
// Top level of the CBOR item skip parser.
`timescale 1ns / 1ps
// Takes a CBOR buffer one byte per transfer and gives one result per byte:
// pending, item complete, malformed, depth exceeded or truncated, with the
// item length so far and the open nesting depth. A byte that ends no item
// goes from the consume step to the result step; a byte that ends an item
// first passes the frame stack pop sequence, which closes each frame it fills.
// A byte skipped after an error gives its result directly. A result stalled
// on the rsp_ side holds off the next byte. The user must write depth_limit
// over the csr_ port only while no byte is in flight; the block does not enforce it.
module cbor_item_skip_parser_core import cisp_pkg::*; #(
   parameter int MAX_NEST = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_buffer_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_item_length,
   output logic [3:0]  rsp_nest_level,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_depth_limit
);

   localparam int LW = $clog2(MAX_NEST + 2);

   cmd_type     cmd;
   sts_type     sts;
   logic [15:0] item_length;
   logic [3:0]  nest_level;
   logic [3:0]  limit_ff;

   // Depth limit register.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) limit_ff <= 4'd8;
      else if (csr_valid) limit_ff <= csr_depth_limit;
   end

   cisp_control u_ctl (
      .clock, .reset, .req_valid, .req_stall, .req_buffer_end,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_item_length, .rsp_nest_level,
      .cmd, .sts, .item_length, .nest_level
   );

   cisp_datapath #(.MAX_NEST(MAX_NEST), .LW(LW)) u_dp (
      .clock, .reset, .cmd, .data_byte(req_data_byte), .depth_limit(limit_ff),
      .sts, .item_length, .nest_level
   );

endmodule

### verif/cbor_item_skip_checker.sv
// Checker for the CBOR item skip parser: predicts each result and compares it.
`timescale 1ns / 1ps
module cbor_item_skip_checker import cisp_pkg::*; #(
   parameter int MAX_NEST = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_buffer_end,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [15:0] rsp_item_length,
   input  logic [3:0]  rsp_nest_level,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [3:0]  csr_depth_limit,
   output int          pending_results,
   output int          failures
);

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] item_length;
      logic [3:0]  nest_level;
   } result_type;

   result_type  expected_q[$];

   // Shadow copy of the parser state.
   logic [33:0] frame_left [MAX_NEST+1];
   logic [2:0]  frame_kind [MAX_NEST+1];
   logic [3:0]  open_frames;
   logic [2:0]  phase;
   logic [2:0]  arg_left;
   logic [31:0] arg_acc;
   logic [2:0]  saved_major;
   logic [31:0] bytes_left;
   logic [15:0] byte_count;
   logic        in_error;
   logic [3:0]  nest_limit;

   function automatic void clear_parse();
      open_frames = '0;
      phase       = PH_HEAD;
      arg_left    = '0;
      arg_acc     = '0;
      saved_major = '0;
      bytes_left  = '0;
      byte_count  = '0;
   endfunction

   // An item ended: count it against the open frames, closing those that fill.
   function automatic logic [2:0] close_item();
      int t;
      forever begin
         if (open_frames == 0) return ST_COMPLETE;
         t = open_frames - 1;
         if (frame_kind[t] == KIND_IARR) return ST_PENDING;
         if (frame_kind[t] == KIND_IMAP) begin
            frame_left[t][0] = ~frame_left[t][0];
            return ST_PENDING;
         end
         frame_left[t] = frame_left[t] - 34'd1;
         if (frame_left[t] != 0) return ST_PENDING;
         open_frames = open_frames - 4'd1;
      end
   endfunction

   function automatic logic [2:0] open_frame(logic [2:0] kind, logic [33:0] count);
      if (open_frames >= MAX_NEST + 1) return ST_DEPTH;
      frame_kind[open_frames] = kind;
      frame_left[open_frames] = count;
      open_frames = open_frames + 4'd1;
      return ST_PENDING;
   endfunction

   function automatic logic [2:0] arg_size(logic [4:0] ai);
      return (ai == 5'd24) ? 3'd1 : ((ai == 5'd25) ? 3'd2 : 3'd4);
   endfunction

   function automatic logic [2:0] finish_head(logic [2:0] ma, logic [31:0] v);
      phase = PH_HEAD;
      case (ma)
         3'd2, 3'd3: begin
            if (v == 0) return close_item();
            bytes_left = v;
            phase = PH_PAYLOAD;
            return ST_PENDING;
         end
         3'd4: begin
            if (v == 0) return close_item();
            return open_frame(KIND_DARR, {2'b00, v});
         end
         3'd5: begin
            if (v == 0) return close_item();
            return open_frame(KIND_DMAP, {1'b0, v, 1'b0});
         end
         3'd6: return open_frame(KIND_TAG, 34'd1);
         default: return close_item();
      endcase
   endfunction

   function automatic logic [2:0] take_byte(logic [7:0] b);
      logic [2:0] ma;
      logic [4:0] ai;
      logic [3:0] lim;
      int t;
      ma  = b[7:5];
      ai  = b[4:0];
      lim = (nest_limit < MAX_NEST) ? nest_limit : 4'(MAX_NEST);
      case (phase)
         PH_HEAD: begin
            // A break may close the innermost indefinite container.
            if (open_frames > 0 && b == 8'hFF) begin
               t = open_frames - 1;
               if (frame_kind[t] == KIND_IARR ||
                   (frame_kind[t] == KIND_IMAP && !frame_left[t][0])) begin
                  open_frames = open_frames - 4'd1;
                  return close_item();
               end
            end
            if (open_frames > lim) return ST_DEPTH;
            if (ai == 5'd31) begin
               if (ma == 3'd2 || ma == 3'd3) begin
                  saved_major = ma;
                  phase = PH_CHEAD;
                  return ST_PENDING;
               end
               if (ma == 3'd4) return open_frame(KIND_IARR, '0);
               if (ma == 3'd5) return open_frame(KIND_IMAP, '0);
               return ST_MALFORMED;
            end
            if (ai >= 5'd27) return ST_MALFORMED;
            if (ai >= 5'd24) begin
               saved_major = ma;
               arg_left = arg_size(ai);
               arg_acc = '0;
               phase = PH_ARG;
               return ST_PENDING;
            end
            return finish_head(ma, {27'd0, ai});
         end
         PH_ARG: begin
            arg_acc = {arg_acc[23:0], b};
            arg_left = arg_left - 3'd1;
            if (arg_left == 0) return finish_head(saved_major, arg_acc);
            return ST_PENDING;
         end
         PH_PAYLOAD: begin
            bytes_left = bytes_left - 32'd1;
            if (bytes_left == 0) begin
               phase = PH_HEAD;
               return close_item();
            end
            return ST_PENDING;
         end
         PH_CHEAD: begin
            if (b == 8'hFF) begin
               phase = PH_HEAD;
               return close_item();
            end
            if (ma != saved_major || ai >= 5'd27) return ST_MALFORMED;
            if (ai >= 5'd24) begin
               arg_left = arg_size(ai);
               arg_acc = '0;
               phase = PH_CARG;
            end else if (ai != 0) begin
               bytes_left = {27'd0, ai};
               phase = PH_CPAY;
            end
            return ST_PENDING;
         end
         PH_CARG: begin
            arg_acc = {arg_acc[23:0], b};
            arg_left = arg_left - 3'd1;
            if (arg_left == 0) begin
               if (arg_acc == 0) phase = PH_CHEAD;
               else begin
                  bytes_left = arg_acc;
                  phase = PH_CPAY;
               end
            end
            return ST_PENDING;
         end
         PH_CPAY: begin
            bytes_left = bytes_left - 32'd1;
            if (bytes_left == 0) phase = PH_CHEAD;
            return ST_PENDING;
         end
         default: return ST_MALFORMED;
      endcase
   endfunction

   function automatic result_type predict_result(logic [7:0] b, logic last);
      result_type res;
      logic [2:0] r;
      res = '0;
      if (in_error) begin
         if (last) begin
            in_error = 1'b0;
            clear_parse();
         end
         return res;
      end
      if (byte_count != 16'hFFFF) byte_count = byte_count + 16'd1;
      r = take_byte(b);
      res.item_length = byte_count;
      res.nest_level = open_frames;
      if (r == ST_COMPLETE) begin
         res.status = ST_COMPLETE;
         clear_parse();
      end else if (r != ST_PENDING) begin
         res.status = r;
         clear_parse();
         in_error = !last;
      end else if (last) begin
         res.status = ST_TRUNC;
         clear_parse();
      end else begin
         res.status = ST_PENDING;
      end
      return res;
   endfunction

   // Watch the three channels on each rising edge.
   always @(posedge clock) begin
      result_type exp_res;
      if (reset) begin
         clear_parse();
         in_error = 1'b0;
         nest_limit = 4'd8;
         expected_q.delete();
         failures = 0;
      end else begin
         if (csr_valid && csr_ready) nest_limit = csr_depth_limit;
         if (req_valid && !req_stall)
            expected_q.push_back(predict_result(req_data_byte, req_buffer_end));
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("result transfer with no result expected");
               failures = failures + 1;
            end else begin
               exp_res = expected_q.pop_front();
               if (rsp_status !== exp_res.status) begin
                  $error("status: expected %0d, actual %0d", exp_res.status, rsp_status);
                  failures = failures + 1;
               end
               if (rsp_item_length !== exp_res.item_length) begin
                  $error("item_length: expected %0d, actual %0d",
                         exp_res.item_length, rsp_item_length);
                  failures = failures + 1;
               end
               if (rsp_nest_level !== exp_res.nest_level) begin
                  $error("nest_level: expected %0d, actual %0d",
                         exp_res.nest_level, rsp_nest_level);
                  failures = failures + 1;
               end
            end
         end
      end
      pending_results = expected_q.size();
   end

endmodule

### verif/tb_cbor_item_skip_parser_core.sv
// Testbench top for the CBOR item skip parser: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_cbor_item_skip_parser_core;
   import cisp_pkg::*;

   localparam int MAX_NEST    = 8;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int RANDOM_BYTES = 1050;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_buffer_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_item_length;
   logic [3:0]  rsp_nest_level;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_depth_limit = 4'd8;

   int          pending_results;
   int          failures;
   int          cycle_count = 0;
   int          bytes_sent = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   logic [7:0]  buffer_q[$];

   cbor_item_skip_parser_core #(.MAX_NEST(MAX_NEST)) dut (.*);

   cbor_item_skip_checker #(.MAX_NEST(MAX_NEST)) checker_inst (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Cycle counter with a hard timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // The result side stalls at random.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // One byte transfer, with random idle cycles in front of it.
   task automatic send_byte(logic [7:0] b, logic last);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         req_data_byte <= 8'($urandom);
         req_buffer_end <= 1'($urandom);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_buffer_end <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   // Send the queued buffer, marking its last byte.
   task automatic send_buffer();
      for (int i = 0; i < buffer_q.size(); i++)
         send_byte(buffer_q[i], i == buffer_q.size() - 1);
      buffer_q.delete();
   endtask

   // Head with a random argument encoding, not always the shortest one.
   task automatic put_head(logic [2:0] ma, logic [31:0] v);
      int form;
      form = $urandom_range(0, 3);
      if (form == 0 && v < 24)
         buffer_q.push_back({ma, v[4:0]});
      else if (form <= 1 && v < 256) begin
         buffer_q.push_back({ma, 5'd24});
         buffer_q.push_back(v[7:0]);
      end else if (form <= 2 && v < 65536) begin
         buffer_q.push_back({ma, 5'd25});
         buffer_q.push_back(v[15:8]);
         buffer_q.push_back(v[7:0]);
      end else begin
         buffer_q.push_back({ma, 5'd26});
         for (int s = 24; s >= 0; s -= 8) buffer_q.push_back(v[s+:8]);
      end
   endtask

   // One well-formed data item with random content and nesting.
   task automatic put_item(int depth);
      int sel;
      int n;
      sel = (depth >= 10) ? $urandom_range(0, 2) : $urandom_range(0, 9);
      case (sel)
         0: put_head(3'($urandom_range(0, 1)),
                     ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 30));
         1: buffer_q.push_back({3'd7, 5'($urandom_range(0, 23))});
         2: begin
            n = $urandom_range(0, 5);
            put_head(3'($urandom_range(2, 3)), n);
            repeat (n) buffer_q.push_back(8'($urandom));
         end
         3: begin
            sel = $urandom_range(2, 3);
            buffer_q.push_back({3'(sel), 5'd31});
            repeat ($urandom_range(0, 3)) begin
               n = $urandom_range(0, 4);
               put_head(3'(sel), n);
               repeat (n) buffer_q.push_back(8'($urandom));
            end
            buffer_q.push_back(8'hFF);
         end
         4: begin
            n = $urandom_range(0, 3);
            put_head(3'd4, n);
            repeat (n) put_item(depth + 1);
         end
         5: begin
            n = $urandom_range(0, 2);
            put_head(3'd5, n);
            repeat (2 * n) put_item(depth + 1);
         end
         6: begin
            buffer_q.push_back(8'h9F);
            repeat ($urandom_range(0, 3)) put_item(depth + 1);
            buffer_q.push_back(8'hFF);
         end
         7: begin
            buffer_q.push_back(8'hBF);
            repeat (2 * $urandom_range(0, 2)) put_item(depth + 1);
            buffer_q.push_back(8'hFF);
         end
         default: begin
            put_head(3'd6, $urandom_range(0, 40));
            put_item(depth + 1);
         end
      endcase
   endtask

   // A random buffer: mostly whole items, sometimes cut short or corrupted.
   task automatic make_buffer();
      int sel;
      int pos;
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
         repeat ($urandom_range(1, 6)) buffer_q.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(1, 3)) put_item(0);
         if (sel < 25) begin
            pos = $urandom_range(1, buffer_q.size());
            while (buffer_q.size() > pos) void'(buffer_q.pop_back());
         end else if (sel < 40) begin
            pos = $urandom_range(0, buffer_q.size() - 1);
            buffer_q[pos] = 8'($urandom);
         end
      end
   endtask

   task automatic write_depth_limit(logic [3:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_depth_limit <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Let every expected result arrive, then let the block settle.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results != 0) @(posedge clock);
      repeat (3 * MAX_NEST + 10) @(posedge clock);
   endtask

   task automatic send_list(input logic [7:0] bytes[$]);
      buffer_q = bytes;
      send_buffer();
   endtask

   initial begin
      logic [3:0] limits[6] = '{4'd8, 4'd0, 4'd3, 4'd15, 4'd1, 4'd8};
      int         idle_mode[4] = '{0, 57, 0, 36};
      int         stall_mode[4] = '{0, 0, 57, 36};
      int         target;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed buffers: argument sizes, reserved sizes, breaks, chunks.
      send_list('{8'h00});
      send_list('{8'h17, 8'h18, 8'hFF});
      send_list('{8'h3A, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
      send_list('{8'h1B, 8'h00, 8'h00});
      send_list('{8'hFF});
      send_list('{8'h9F, 8'h01, 8'hFF, 8'hBF, 8'h00, 8'hFF, 8'h00});
      send_list('{8'h5F, 8'h41, 8'hAA, 8'h40, 8'hFF});
      send_list('{8'h7F, 8'h41, 8'h00});
      send_list('{8'hBA, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
      send_list('{8'hC0});
      send_list('{8'hDF, 8'h1F});
      drain();

      // Random phases, each setting a nesting limit and an idling pattern.
      target = bytes_sent;
      for (int p = 0; p < 6; p++) begin
         write_depth_limit(limits[p]);
         idle_pct = idle_mode[p % 4];
         stall_pct = stall_mode[p % 4];
         target += RANDOM_BYTES / 6;
         while (bytes_sent < target) begin
            make_buffer();
            send_buffer();
         end
         drain();
      end
      stall_pct = 0;
      drain();

      if (failures == 0 && pending_results == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### sim.f
rtl/cisp_pkg.sv
rtl/cisp_datapath.sv
rtl/cisp_control.sv
rtl/cbor_item_skip_parser_core.sv
verif/cbor_item_skip_checker.sv
verif/tb_cbor_item_skip_parser_core.sv
